/* design/gasp_pkg.sv */
`timescale 1ns / 1ps

package gasp_pkg;

    // Limits of the atlas.
    localparam int MAX_PAGES   = 16;
    localparam int MAX_SIDE    = 4096;
    localparam int QUEUE_DEPTH = 2;

    localparam int SIDE_W = 13;
    localparam int POS_W  = 12;
    localparam int PAGE_W = 4;

    // Configuration register indexes.
    localparam logic CFG_ATLAS_WIDTH  = 1'b0;
    localparam logic CFG_ATLAS_HEIGHT = 1'b1;

    localparam logic [SIDE_W-1:0] RESET_SIDE = SIDE_W'(1024);

    // Command codes.
    localparam logic CMD_PLACE = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    // Source pixel formats.
    localparam logic [1:0] FMT_BGRA = 2'd0;
    localparam logic [1:0] FMT_GRAY = 2'd1;
    localparam logic [1:0] FMT_MONO = 2'd2;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_NO_PAGES  = 3'd2,
        ST_OUTSIDE   = 3'd3,
        ST_NO_GLYPH  = 3'd4
    } t_status;

    typedef struct packed {
        logic              cmd;
        logic [SIDE_W-1:0] glyph_width;
        logic [SIDE_W-1:0] glyph_height;
        logic [1:0]        pixel_format;
        logic [7:0]        chan_b;
        logic [7:0]        chan_g;
        logic [7:0]        chan_r;
        logic [7:0]        chan_a;
        logic              mono_bit;
    } t_in_word;

    typedef struct packed {
        logic              is_pixel;
        logic [2:0]        status;
        logic [PAGE_W-1:0] page;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic              color_src;
        logic [7:0]        out_r;
        logic [7:0]        out_g;
        logic [7:0]        out_b;
        logic [7:0]        out_a;
    } t_out_word;

    // A classified item: the result word, with the color channels still
    // premultiplied when need_div is set.
    typedef struct packed {
        t_out_word word;
        logic      need_div;
    } t_job;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_stat;

endpackage

/* design/glyph_atlas_shelf_packer_writer_unit.sv */
`timescale 1ns / 1ps

// Glyph atlas shelf packer and texel writer. A place word packs a glyph into
// the atlas pages and returns its page and origin; the pixel words that follow
// come back with atlas coordinates in row-major order as straight-alpha RGBA.
// Every input word gives exactly one output word, in order. The front end
// takes one word per cycle while its queue has room; placements and texels
// that need no division pass through a queue entry and then the output
// register. A premultiplied texel with partial alpha goes through the
// 16-step divider in the back end, which takes no new word until the
// quotient is in the output register. Configuration writes take effect at
// once and are meant for idle periods only.
module glyph_atlas_shelf_packer_writer_unit #(
    parameter int QUEUE_DEPTH = gasp_pkg::QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [12:0]          i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  gasp_pkg::t_in_word   i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output gasp_pkg::t_out_word  o_out_word
);

    gasp_pkg::t_job        push_job, head_job;
    gasp_pkg::t_queue_stat qstat;
    logic                  push, pop;

    // Packer and classifier.
    gasp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .i_qstat    (qstat),
        .o_push     (push),
        .o_job      (push_job)
    );

    // Queue between front and back.
    gasp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_job  (push_job),
        .i_pop  (pop),
        .o_head (head_job),
        .o_stat (qstat)
    );

    // Unpremultiply and output register.
    gasp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head_job),
        .i_qstat    (qstat),
        .o_pop      (pop),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_word (o_out_word)
    );

endmodule

/* design/gasp_front.sv */
`timescale 1ns / 1ps

module gasp_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [12:0]         i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  gasp_pkg::t_in_word  i_in_word,
    input  gasp_pkg::t_queue_stat i_qstat,
    output logic                o_push,
    output gasp_pkg::t_job      o_job
);

    localparam int SW = gasp_pkg::SIDE_W;
    localparam int PW = gasp_pkg::PAGE_W;

    logic [SW-1:0] r_atlas_w, r_atlas_h;
    logic [SW-1:0] r_cx, r_cy, r_rh, r_aw_g, r_ah_g, r_col, r_row;
    logic [SW-1:0] n_cx, n_cy, n_rh, n_aw_g, n_ah_g, n_col, n_row;
    logic [PW-1:0] r_page, n_page;
    logic [11:0]   r_ox, r_oy, n_ox, n_oy;
    logic [1:0]    r_fmt, n_fmt;
    logic          r_active, n_active;

    logic [SW-1:0] aw, ah, cx1, cy1, rh1;
    logic          wrap, need_page;
    logic [SW:0]   col_inc, row_inc;
    logic          accept;
    gasp_pkg::t_job job;

    assign o_in_ready = !i_qstat.full;
    assign accept     = i_in_valid && o_in_ready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_atlas_w <= gasp_pkg::RESET_SIDE;
            r_atlas_h <= gasp_pkg::RESET_SIDE;
        end else if (i_cfg_we) begin
            if (i_cfg_index == gasp_pkg::CFG_ATLAS_WIDTH) begin
                r_atlas_w <= i_cfg_data;
            end else begin
                r_atlas_h <= i_cfg_data;
            end
        end
    end

    // Page sides, with zero read as one and large values clamped.
    always_comb begin
        aw = r_atlas_w;
        ah = r_atlas_h;
        if (aw == '0) aw = SW'(1);
        else if (aw > SW'(gasp_pkg::MAX_SIDE)) aw = SW'(gasp_pkg::MAX_SIDE);
        if (ah == '0) ah = SW'(1);
        else if (ah > SW'(gasp_pkg::MAX_SIDE)) ah = SW'(gasp_pkg::MAX_SIDE);
    end

    // Classify the word and work out the packer's next state.
    always_comb begin
        n_cx = r_cx; n_cy = r_cy; n_rh = r_rh; n_page = r_page;
        n_ox = r_ox; n_oy = r_oy; n_aw_g = r_aw_g; n_ah_g = r_ah_g;
        n_col = r_col; n_row = r_row; n_fmt = r_fmt; n_active = r_active;
        job = '0;
        wrap = ({1'b0, r_cx} + {1'b0, i_in_word.glyph_width}) > {1'b0, aw};
        cx1 = wrap ? '0 : r_cx;
        cy1 = wrap ? SW'(r_cy + r_rh) : r_cy;
        rh1 = wrap ? '0 : r_rh;
        need_page = ({1'b0, cy1} + {1'b0, i_in_word.glyph_height}) > {1'b0, ah};
        col_inc = {1'b0, r_col} + (SW+1)'(1);
        row_inc = {1'b0, r_row} + (SW+1)'(1);

        if (i_in_word.cmd == gasp_pkg::CMD_PLACE) begin
            job.word.is_pixel  = 1'b0;
            job.word.page      = r_page;
            job.word.color_src = (i_in_word.pixel_format == gasp_pkg::FMT_BGRA);
            n_active = 1'b0;
            if (i_in_word.glyph_width == '0 || i_in_word.glyph_height == '0) begin
                job.word.status = gasp_pkg::ST_EMPTY;
            end else if (i_in_word.glyph_width > aw || i_in_word.glyph_height > ah) begin
                job.word.status = gasp_pkg::ST_OUTSIDE;
            end else if (need_page && r_page >= PW'(gasp_pkg::MAX_PAGES - 1)) begin
                // The shelf wrap stays even though the glyph is refused.
                job.word.status = gasp_pkg::ST_NO_PAGES;
                n_cx = cx1; n_cy = cy1; n_rh = rh1;
            end else begin
                if (need_page) begin
                    n_page = r_page + PW'(1);
                    cx1 = '0; cy1 = '0; rh1 = '0;
                end
                n_ox = cx1[11:0];
                n_oy = cy1[11:0];
                n_rh = (i_in_word.glyph_height > rh1) ? i_in_word.glyph_height : rh1;
                n_cx = SW'(cx1 + i_in_word.glyph_width);
                n_cy = cy1;
                n_aw_g = i_in_word.glyph_width;
                n_ah_g = i_in_word.glyph_height;
                n_fmt = i_in_word.pixel_format;
                n_col = '0;
                n_row = '0;
                n_active = 1'b1;
                job.word.status = gasp_pkg::ST_OK;
                job.word.page   = n_page;
                job.word.pos_x  = n_ox;
                job.word.pos_y  = n_oy;
            end
        end else if (!r_active) begin
            job.word.is_pixel = 1'b1;
            job.word.status   = gasp_pkg::ST_NO_GLYPH;
        end else begin
            job.word.is_pixel  = 1'b1;
            job.word.status    = gasp_pkg::ST_OK;
            job.word.page      = r_page;
            job.word.pos_x     = r_ox + r_col[11:0];
            job.word.pos_y     = r_oy + r_row[11:0];
            job.word.color_src = (r_fmt == gasp_pkg::FMT_BGRA);
            case (r_fmt)
                gasp_pkg::FMT_BGRA: begin
                    job.word.out_r = i_in_word.chan_r;
                    job.word.out_g = i_in_word.chan_g;
                    job.word.out_b = i_in_word.chan_b;
                    job.word.out_a = i_in_word.chan_a;
                    job.need_div   = (i_in_word.chan_a != 8'd0) &&
                                     (i_in_word.chan_a != 8'd255);
                end
                gasp_pkg::FMT_GRAY: begin
                    job.word.out_r = 8'd255;
                    job.word.out_g = 8'd255;
                    job.word.out_b = 8'd255;
                    job.word.out_a = i_in_word.chan_a;
                end
                gasp_pkg::FMT_MONO: begin
                    job.word.out_r = 8'd255;
                    job.word.out_g = 8'd255;
                    job.word.out_b = 8'd255;
                    job.word.out_a = i_in_word.mono_bit ? 8'd255 : 8'd0;
                end
                default: begin
                    job.word.out_a = 8'd0;
                end
            endcase
            // Row-major walk over the glyph.
            if (col_inc >= {1'b0, r_aw_g}) begin
                n_col = '0;
                if (row_inc >= {1'b0, r_ah_g}) begin
                    n_row = '0;
                    n_active = 1'b0;
                end else begin
                    n_row = row_inc[SW-1:0];
                end
            end else begin
                n_col = col_inc[SW-1:0];
            end
        end
    end

    // Packer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= '0; r_cy <= '0; r_rh <= '0; r_page <= '0;
            r_ox <= '0; r_oy <= '0; r_aw_g <= '0; r_ah_g <= '0;
            r_col <= '0; r_row <= '0; r_fmt <= '0; r_active <= 1'b0;
        end else if (accept) begin
            r_cx <= n_cx; r_cy <= n_cy; r_rh <= n_rh; r_page <= n_page;
            r_ox <= n_ox; r_oy <= n_oy; r_aw_g <= n_aw_g; r_ah_g <= n_ah_g;
            r_col <= n_col; r_row <= n_row; r_fmt <= n_fmt; r_active <= n_active;
        end
    end

    assign o_push = accept;
    assign o_job  = job;

endmodule

/* design/gasp_queue.sv */
`timescale 1ns / 1ps

module gasp_queue #(
    parameter int DEPTH = gasp_pkg::QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  gasp_pkg::t_job        i_job,
    input  logic                  i_pop,
    output gasp_pkg::t_job        o_head,
    output gasp_pkg::t_queue_stat o_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    gasp_pkg::t_job r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_count;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    assign o_head       = r_mem[r_rptr];
    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

/* design/gasp_back.sv */
`timescale 1ns / 1ps

module gasp_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  gasp_pkg::t_job        i_head,
    input  gasp_pkg::t_queue_stat i_qstat,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output gasp_pkg::t_out_word   o_out_word
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state r_state, n_state;
    gasp_pkg::t_out_word r_job, r_out;
    logic        r_out_valid;
    logic [3:0]  r_step;
    logic [15:0] r_num [3];
    logic [7:0]  r_rem [3];
    logic [8:0]  trial [3];
    logic [7:0]  chan  [3];
    logic [7:0]  quo   [3];
    logic        out_free, take;
    gasp_pkg::t_out_word done_word;

    assign out_free = !r_out_valid || i_out_ready;
    assign take     = (r_state == S_IDLE) && !i_qstat.empty && out_free;
    assign o_pop    = take;

    assign chan[0] = i_head.word.out_r;
    assign chan[1] = i_head.word.out_g;
    assign chan[2] = i_head.word.out_b;

    // One restoring divide step per lane and cycle, with saturation at 255.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            trial[k] = {r_rem[k], r_num[k][15]};
            quo[k]   = (r_num[k][15:8] != 8'd0) ? 8'd255 : r_num[k][7:0];
        end
        done_word       = r_job;
        done_word.out_r = quo[0];
        done_word.out_g = quo[1];
        done_word.out_b = quo[2];
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (take && i_head.need_div) n_state = S_DIV;
            S_DIV:  if (r_step == 4'd15) n_state = S_DONE;
            S_DONE: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((take && !i_head.need_div) || (r_state == S_DONE && out_free)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Divider lanes and the result register.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_job  <= i_head.word;
            r_step <= '0;
            for (int k = 0; k < 3; k++) begin
                r_num[k] <= {chan[k], 8'd0} - {8'd0, chan[k]};
                r_rem[k] <= '0;
            end
        end else if (r_state == S_DIV) begin
            r_step <= r_step + 4'd1;
            for (int k = 0; k < 3; k++) begin
                if (trial[k] >= {1'b0, r_job.out_a}) begin
                    r_rem[k] <= 8'(trial[k] - {1'b0, r_job.out_a});
                    r_num[k] <= {r_num[k][14:0], 1'b1};
                end else begin
                    r_rem[k] <= trial[k][7:0];
                    r_num[k] <= {r_num[k][14:0], 1'b0};
                end
            end
        end
        if (take && !i_head.need_div) begin
            r_out <= i_head.word;
        end else if (r_state == S_DONE && out_free) begin
            r_out <= done_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic                i_cfg_index;
    logic [12:0]         i_cfg_data;
    logic                i_in_valid;
    logic                o_in_ready;
    gasp_pkg::t_in_word  i_in_word;
    logic                o_out_valid;
    logic                i_out_ready;
    gasp_pkg::t_out_word o_out_word;

    glyph_atlas_shelf_packer_writer_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_word (o_out_word)
    );

    // Shadow copy of the packer state and the page size registers.
    logic [12:0] atlas_w_reg, atlas_h_reg;
    logic [12:0] cur_x, cur_y, shelf_h, glyph_w, glyph_h, col_cnt, row_cnt;
    logic [3:0]  cur_page;
    logic [11:0] org_x, org_y;
    logic [1:0]  glyph_fmt;
    logic        glyph_on;

    gasp_pkg::t_out_word expected_words[$];
    int        error_count;
    bit        sender_idles;
    bit        receiver_idles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [12:0] clamp_page_side(logic [12:0] v);
        if (v == 13'd0) begin
            return 13'd1;
        end
        if (v > 13'(gasp_pkg::MAX_SIDE)) begin
            return 13'(gasp_pkg::MAX_SIDE);
        end
        return v;
    endfunction

    function automatic logic [7:0] unpremultiply(logic [7:0] c, logic [7:0] a);
        int unsigned q;
        if (a == 8'd0 || a == 8'd255) begin
            return c;
        end
        q = (c * 255) / a;
        return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    // Work out the output word for one accepted input word and update the shadow state.
    task automatic predict_word(input gasp_pkg::t_in_word w);
        gasp_pkg::t_out_word o;
        logic [12:0] aw, ah;
        o = '0;
        if (w.cmd == gasp_pkg::CMD_PLACE) begin
            aw = clamp_page_side(atlas_w_reg);
            ah = clamp_page_side(atlas_h_reg);
            glyph_on = 1'b0;
            o.page = cur_page;
            o.color_src = (w.pixel_format == gasp_pkg::FMT_BGRA);
            if (w.glyph_width == 0 || w.glyph_height == 0) begin
                o.status = gasp_pkg::ST_EMPTY;
            end else if (w.glyph_width > aw || w.glyph_height > ah) begin
                o.status = gasp_pkg::ST_OUTSIDE;
            end else begin
                if (32'(cur_x) + w.glyph_width > aw) begin
                    cur_y = cur_y + shelf_h;
                    cur_x = '0;
                    shelf_h = '0;
                end
                if (32'(cur_y) + w.glyph_height > ah &&
                    32'(cur_page) + 1 >= gasp_pkg::MAX_PAGES) begin
                    o.status = gasp_pkg::ST_NO_PAGES;
                end else begin
                    if (32'(cur_y) + w.glyph_height > ah) begin
                        cur_page = cur_page + 4'd1;
                        cur_x = '0;
                        cur_y = '0;
                        shelf_h = '0;
                    end
                    org_x = cur_x[11:0];
                    org_y = cur_y[11:0];
                    if (w.glyph_height > shelf_h) begin
                        shelf_h = w.glyph_height;
                    end
                    cur_x = cur_x + w.glyph_width;
                    glyph_w = w.glyph_width;
                    glyph_h = w.glyph_height;
                    glyph_fmt = w.pixel_format;
                    col_cnt = '0;
                    row_cnt = '0;
                    glyph_on = 1'b1;
                    o.status = gasp_pkg::ST_OK;
                    o.page = cur_page;
                    o.pos_x = org_x;
                    o.pos_y = org_y;
                end
            end
        end else begin
            o.is_pixel = 1'b1;
            if (!glyph_on) begin
                o.status = gasp_pkg::ST_NO_GLYPH;
            end else begin
                o.status = gasp_pkg::ST_OK;
                o.page = cur_page;
                o.pos_x = org_x + col_cnt[11:0];
                o.pos_y = org_y + row_cnt[11:0];
                o.color_src = (glyph_fmt == gasp_pkg::FMT_BGRA);
                case (glyph_fmt)
                    gasp_pkg::FMT_BGRA: begin
                        o.out_r = unpremultiply(w.chan_r, w.chan_a);
                        o.out_g = unpremultiply(w.chan_g, w.chan_a);
                        o.out_b = unpremultiply(w.chan_b, w.chan_a);
                        o.out_a = w.chan_a;
                    end
                    gasp_pkg::FMT_GRAY: begin
                        o.out_r = 8'd255;
                        o.out_g = 8'd255;
                        o.out_b = 8'd255;
                        o.out_a = w.chan_a;
                    end
                    gasp_pkg::FMT_MONO: begin
                        o.out_r = 8'd255;
                        o.out_g = 8'd255;
                        o.out_b = 8'd255;
                        o.out_a = w.mono_bit ? 8'd255 : 8'd0;
                    end
                    default: begin
                    end
                endcase
                col_cnt = col_cnt + 13'd1;
                if (col_cnt >= glyph_w) begin
                    col_cnt = '0;
                    row_cnt = row_cnt + 13'd1;
                    if (row_cnt >= glyph_h) begin
                        row_cnt = '0;
                        glyph_on = 1'b0;
                    end
                end
            end
        end
        expected_words.push_back(o);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch in %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Compare each accepted output word with the oldest expected word.
    always @(posedge i_clk) begin
        gasp_pkg::t_out_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_words.size() == 0) begin
                report_mismatch("unexpected word", 1, 0);
            end else begin
                want = expected_words.pop_front();
                if (o_out_word.is_pixel !== want.is_pixel)
                    report_mismatch("is_pixel", o_out_word.is_pixel, want.is_pixel);
                if (o_out_word.status !== want.status)
                    report_mismatch("status", o_out_word.status, want.status);
                if (o_out_word.page !== want.page)
                    report_mismatch("page", o_out_word.page, want.page);
                if (o_out_word.pos_x !== want.pos_x)
                    report_mismatch("pos_x", o_out_word.pos_x, want.pos_x);
                if (o_out_word.pos_y !== want.pos_y)
                    report_mismatch("pos_y", o_out_word.pos_y, want.pos_y);
                if (o_out_word.color_src !== want.color_src)
                    report_mismatch("color_src", o_out_word.color_src, want.color_src);
                if (o_out_word.out_r !== want.out_r)
                    report_mismatch("out_r", o_out_word.out_r, want.out_r);
                if (o_out_word.out_g !== want.out_g)
                    report_mismatch("out_g", o_out_word.out_g, want.out_g);
                if (o_out_word.out_b !== want.out_b)
                    report_mismatch("out_b", o_out_word.out_b, want.out_b);
                if (o_out_word.out_a !== want.out_a)
                    report_mismatch("out_a", o_out_word.out_a, want.out_a);
            end
        end
    end

    // The receiver stalls at random unless idling is switched off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= !receiver_idles || ($urandom_range(99) >= 35);
        end
    end

    // Send one word, with an optional random gap in front of it. Valid stays
    // high after acceptance so that the next word follows without a gap; the
    // caller drops it through stop_sending when no word follows.
    task automatic send_word(input gasp_pkg::t_in_word w);
        while (sender_idles && $urandom_range(99) < 35) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word <= w;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        predict_word(w);
    endtask

    // Drop valid once the last word has been accepted.
    task automatic stop_sending();
        i_in_valid <= 1'b0;
    endtask

    function automatic gasp_pkg::t_in_word place_word(int w, int h, logic [1:0] fmt);
        gasp_pkg::t_in_word p;
        p = '0;
        p.cmd = gasp_pkg::CMD_PLACE;
        p.glyph_width = 13'(w);
        p.glyph_height = 13'(h);
        p.pixel_format = fmt;
        p.chan_b = 8'($urandom);
        p.chan_g = 8'($urandom);
        p.chan_r = 8'($urandom);
        p.chan_a = 8'($urandom);
        p.mono_bit = 1'($urandom);
        return p;
    endfunction

    function automatic gasp_pkg::t_in_word pixel_word();
        gasp_pkg::t_in_word p;
        logic [63:0]        rnd;
        rnd = {$urandom, $urandom};
        p = rnd[$bits(gasp_pkg::t_in_word)-1:0];
        p.cmd = gasp_pkg::CMD_PIXEL;
        return p;
    endfunction

    task automatic send_pixels(int n);
        for (int i = 0; i < n; i++) begin
            send_word(pixel_word());
        end
    endtask

    // Wait until every word has come back, plus the divider latency.
    task automatic drain_outputs();
        stop_sending();
        while (expected_words.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [12:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == gasp_pkg::CFG_ATLAS_WIDTH) begin
            atlas_w_reg = value;
        end else begin
            atlas_h_reg = value;
        end
        @(posedge i_clk);
    endtask

    // Field extremes, every format and the empty, outside and no-glyph statuses.
    task automatic test_directed();
        gasp_pkg::t_in_word p;
        send_word(pixel_word());
        send_word(place_word(0, 5, gasp_pkg::FMT_GRAY));
        send_word(place_word(5, 0, gasp_pkg::FMT_BGRA));
        send_word(place_word(4096, 4, gasp_pkg::FMT_MONO));
        send_word(place_word(8191, 8191, gasp_pkg::FMT_GRAY));
        send_word(place_word(2, 2, gasp_pkg::FMT_BGRA));
        p = pixel_word();
        p.chan_a = 8'd0;
        send_word(p);
        p = pixel_word();
        p.chan_a = 8'd255;
        send_word(p);
        p = pixel_word();
        p.chan_a = 8'd1;
        p.chan_r = 8'd255;
        send_word(p);
        send_pixels(1);
        send_word(pixel_word());
        send_word(place_word(3, 1, gasp_pkg::FMT_MONO));
        send_pixels(3);
        send_word(place_word(1, 1, 2'd3));
        send_pixels(1);
        send_word(place_word(1024, 1024, gasp_pkg::FMT_GRAY));
        send_word(place_word(1, 1, gasp_pkg::FMT_GRAY));
        send_pixels(1);
    endtask

    // Tiny pages exhaust every page and hit the out of pages status.
    task automatic test_page_exhaustion();
        drain_outputs();
        write_reg(gasp_pkg::CFG_ATLAS_WIDTH, 13'd0);
        write_reg(gasp_pkg::CFG_ATLAS_HEIGHT, 13'd2);
        for (int i = 0; i < 40; i++) begin
            send_word(place_word(1, $urandom_range(1, 2), gasp_pkg::FMT_MONO));
        end
        send_word(place_word(2, 1, gasp_pkg::FMT_MONO));
        drain_outputs();
        write_reg(gasp_pkg::CFG_ATLAS_WIDTH, 13'd8191);
        write_reg(gasp_pkg::CFG_ATLAS_HEIGHT, 13'd4097);
        send_word(place_word(4096, 4096, gasp_pkg::FMT_GRAY));
        send_word(place_word(4096, 2, gasp_pkg::FMT_BGRA));
    endtask

    // Mostly well formed glyphs with random content, some noise.
    task automatic test_random_glyphs(int budget, int side);
        int sent;
        int w, h, n;
        sent = 0;
        while (sent < budget) begin
            if ($urandom_range(9) == 0) begin
                send_word(($urandom_range(1) != 0) ? pixel_word()
                          : place_word($urandom_range(0, side + 2),
                                       $urandom_range(0, side + 2), 2'($urandom)));
                sent++;
            end else begin
                w = $urandom_range(1, side);
                h = $urandom_range(1, side);
                send_word(place_word(w, h, 2'($urandom)));
                n = w * h;
                if ($urandom_range(7) == 0) begin
                    n = $urandom_range(0, n);
                end
                send_pixels(n);
                sent += n + 1;
            end
        end
    endtask

    task automatic test_random();
        drain_outputs();
        write_reg(gasp_pkg::CFG_ATLAS_WIDTH, 13'd20);
        write_reg(gasp_pkg::CFG_ATLAS_HEIGHT, 13'd12);
        test_random_glyphs(400, 6);
        // The sender holds off until everything has come back.
        stop_sending();
        while (expected_words.size() != 0) begin
            @(posedge i_clk);
        end
        sender_idles = 1'b0;
        receiver_idles = 1'b0;
        test_random_glyphs(250, 5);
        sender_idles = 1'b1;
        receiver_idles = 1'b1;
        drain_outputs();
        write_reg(gasp_pkg::CFG_ATLAS_WIDTH, 13'd4096);
        write_reg(gasp_pkg::CFG_ATLAS_HEIGHT, 13'd1);
        test_random_glyphs(150, 8);
        drain_outputs();
        write_reg(gasp_pkg::CFG_ATLAS_WIDTH, 13'd1);
        write_reg(gasp_pkg::CFG_ATLAS_HEIGHT, 13'd4096);
        test_random_glyphs(150, 4);
        drain_outputs();
        write_reg(gasp_pkg::CFG_ATLAS_WIDTH, 13'd9);
        write_reg(gasp_pkg::CFG_ATLAS_HEIGHT, 13'd7);
        test_random_glyphs(250, 4);
    endtask

    initial begin
        error_count = 0;
        sender_idles = 1'b1;
        receiver_idles = 1'b1;
        atlas_w_reg = gasp_pkg::RESET_SIDE;
        atlas_h_reg = gasp_pkg::RESET_SIDE;
        {cur_x, cur_y, shelf_h, glyph_w, glyph_h, col_cnt, row_cnt} = '0;
        {cur_page, org_x, org_y, glyph_fmt, glyph_on} = '0;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= gasp_pkg::CFG_ATLAS_WIDTH;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        i_in_word <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_page_exhaustion();
        test_random();
        drain_outputs();
        if (error_count == 0) begin
            $display("[glyph_atlas_shelf_packer_writer_unit] OK");
        end else begin
            $display("[glyph_atlas_shelf_packer_writer_unit] ERROR");
        end
        $finish;
    end

    // Generous bound on the whole run.
    initial begin
        #20ms;
        $display("[glyph_atlas_shelf_packer_writer_unit] ERROR");
        $finish;
    end

endmodule

/* filelist.f */
design/gasp_pkg.sv
design/gasp_front.sv
design/gasp_queue.sv
design/gasp_back.sv
design/glyph_atlas_shelf_packer_writer_unit.sv
test/testbench.sv
